[design/jtl_pkg.sv]
`default_nettype none

package jtl_pkg;

  localparam int OFFSET_BITS  = 32;
  localparam int LINE_BITS    = 32;
  localparam int OUT_BITS     = 32;
  localparam int MAX_TOKENS   = 3;
  localparam int TOK_IDX_BITS = $clog2(MAX_TOKENS);
  localparam int CNT_BITS     = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [LINE_BITS-1:0]   line_t;

  typedef enum logic [3:0] {
    KIND_COLON  = 4'd0,
    KIND_COMMA  = 4'd1,
    KIND_LBRACE = 4'd2,
    KIND_RBRACE = 4'd3,
    KIND_LBRACK = 4'd4,
    KIND_RBRACK = 4'd5,
    KIND_STRING = 4'd6,
    KIND_NUMBER = 4'd7,
    KIND_ERROR  = 4'd8,
    KIND_END    = 4'd9
  } kind_e;

  typedef struct packed {
    kind_e kind;
    pos_t  offset;
    pos_t  length;
    line_t line;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] toks;
    logic [CNT_BITS-1:0]   count;
  } bundle_t;

  function automatic tok_t mk_tok(kind_e kind, pos_t offset, pos_t length, line_t line);
    tok_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = length;
    t.line   = line;
    return t;
  endfunction

  function automatic logic [OUT_BITS-1:0] fit_out(pos_t v);
    logic [OFFSET_BITS+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, v};
    return w[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[design/jtl_if.sv]
`default_nettype none

interface jtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jtl_token_if;
  import jtl_pkg::*;

  logic                valid;
  logic                ready;
  kind_e               token_kind;
  logic [OUT_BITS-1:0] token_offset;
  logic [OUT_BITS-1:0] token_length;
  logic [LINE_BITS-1:0] line_index;
  logic                last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output line_index, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input line_index, input last_of_run,
                output ready);
endinterface

`default_nettype wire

[design/jtl_front.sv]
`default_nettype none

module jtl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  jtl_byte_if.sink          in_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output jtl_pkg::bundle_t  push_data_o
);
  import jtl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_INT  = 2'd2,
    MODE_FRAC = 2'd3
  } mode_e;

  mode_e   mode_q, mode_d;
  pos_t    pos_q, pos_d;
  pos_t    begin_q, begin_d;
  line_t   line_q, line_d;
  logic    accept;
  bundle_t bundle;

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = accept && (bundle.count != '0);
  assign push_data_o  = bundle;

  always_comb begin
    logic [7:0]          b;
    pos_t                p;
    pos_t                nxt;
    logic                cls;
    logic [CNT_BITS-1:0] n;

    b       = in_i.data_byte;
    p       = pos_q;
    nxt     = pos_q + pos_t'(1);
    cls     = 1'b0;
    n       = '0;
    bundle  = '0;
    mode_d  = mode_q;
    begin_d = begin_q;
    line_d  = line_q;
    pos_d   = nxt;

    case (mode_q)
      MODE_STR: begin
        if (b == CH_QUOTE) begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_STRING, begin_q, p - begin_q, line_q);
          n      = n + CNT_BITS'(1);
          mode_d = MODE_IDLE;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (b inside {[CH_0:CH_9]}) begin
          mode_d = mode_q;
        end else if (b == CH_DOT && mode_q == MODE_INT) begin
          mode_d = MODE_FRAC;
        end else begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_NUMBER, begin_q, p - begin_q, line_q);
          n      = n + CNT_BITS'(1);
          mode_d = MODE_IDLE;
          cls    = 1'b1;
        end
      end
      default: begin
        cls = 1'b1;
      end
    endcase

    if (cls) begin
      case (b)
        CH_SPACE, CH_TAB, CH_CR: begin
          line_d = line_q;
        end
        CH_LF: begin
          line_d = line_q + line_t'(1);
        end
        CH_COLON: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_COLON, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_COMMA: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_COMMA, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_LBRACE: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_LBRACE, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_RBRACE: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_RBRACE, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_LBRACK: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_LBRACK, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_RBRACK: begin
          bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_RBRACK, p, pos_t'(1), line_q);
          n = n + CNT_BITS'(1);
        end
        CH_QUOTE: begin
          mode_d  = MODE_STR;
          begin_d = nxt;
        end
        default: begin
          if (b == CH_MINUS || b inside {[CH_0:CH_9]}) begin
            mode_d  = MODE_INT;
            begin_d = p;
          end else begin
            bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_ERROR, p, pos_t'(1), line_q);
            n = n + CNT_BITS'(1);
          end
        end
      endcase
    end

    if (in_i.final_byte) begin
      if (mode_d == MODE_STR) begin
        bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_STRING, begin_d, nxt - begin_d, line_d);
        n = n + CNT_BITS'(1);
      end else if (mode_d == MODE_INT || mode_d == MODE_FRAC) begin
        bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_NUMBER, begin_d, nxt - begin_d, line_d);
        n = n + CNT_BITS'(1);
      end
      bundle.toks[TOK_IDX_BITS'(n)] = mk_tok(KIND_END, nxt, '0, line_d);
      n       = n + CNT_BITS'(1);
      mode_d  = MODE_IDLE;
      begin_d = '0;
      line_d  = '0;
      pos_d   = '0;
    end

    bundle.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      begin_q <= '0;
      line_q  <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

[design/jtl_queue.sv]
`default_nettype none

module jtl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  jtl_pkg::bundle_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output jtl_pkg::bundle_t pop_data_o,
  input  logic             pop_ready_i
);
  import jtl_pkg::*;

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_BITS'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/jtl_back.sv]
`default_nettype none

module jtl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  jtl_pkg::bundle_t pop_data_i,
  output logic             pop_ready_o,
  jtl_token_if.source      out_o
);
  import jtl_pkg::*;

  logic [TOK_IDX_BITS-1:0] idx_q;
  logic                    out_valid_q;
  kind_e                   kind_q;
  logic [OUT_BITS-1:0]     offset_q;
  logic [OUT_BITS-1:0]     length_q;
  line_t                   line_q;
  logic                    last_q;
  logic                    load;
  logic                    take;
  logic                    last;
  tok_t                    cur;

  assign load        = !out_valid_q || out_o.ready;
  assign take        = load && pop_valid_i;
  assign cur         = pop_data_i.toks[idx_q];
  assign last        = (idx_q == TOK_IDX_BITS'(pop_data_i.count - CNT_BITS'(1)));
  assign pop_ready_o = take && last;

  assign out_o.valid        = out_valid_q;
  assign out_o.token_kind   = kind_q;
  assign out_o.token_offset = offset_q;
  assign out_o.token_length = length_q;
  assign out_o.line_index   = line_q;
  assign out_o.last_of_run  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= pop_valid_i;
      if (pop_valid_i) begin
        idx_q <= last ? '0 : idx_q + TOK_IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= cur.kind;
      offset_q <= fit_out(cur.offset);
      length_q <= fit_out(cur.length);
      line_q   <= cur.line;
      last_q   <= last;
    end
  end

endmodule

`default_nettype wire

[design/json_token_lexer_core.sv]
`default_nettype none

// This lexer takes one byte of JSON text per cycle while the queue has room, and emits
// tokens with kind, offset, length and line index; a set final_byte ends the text, adds
// an end token and returns all counters to zero for the next text. The front stage
// classifies each byte and places the up to three tokens that it causes into a four-entry
// queue, and the back stage delivers one token per cycle from a registered output while
// the output is ready. Bytes that cause no token, such as whitespace or string contents,
// take no queue slot, so the input runs at one byte per cycle as long as the output keeps
// up. A byte's tokens are registered in the queue and then in the output register; the
// single-token output port sets the sustained rate when bytes cause more than one token.
module json_token_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  jtl_byte_if.sink    in_i,
  jtl_token_if.source out_o
);
  import jtl_pkg::*;

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  bundle_t pop_data;

  jtl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  jtl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  jtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[design/jtl_checker.sv]
`default_nettype none

module jtl_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input jtl_pkg::kind_e          token_kind_i,
  input logic [jtl_pkg::OUT_BITS-1:0] token_offset_i,
  input logic [jtl_pkg::OUT_BITS-1:0] token_length_i,
  input logic                    last_of_run_i
);
  import jtl_pkg::*;

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Token valid dropped while stalled.");

  a_payload_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(token_kind_i) && $stable(token_offset_i) && $stable(last_of_run_i))
    else $error("Token payload changed while stalled.");

  a_end_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == KIND_END |-> last_of_run_i && token_length_i == '0)
    else $error("End token must close its run with zero length.");

  a_single_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == KIND_COLON || token_kind_i == KIND_COMMA ||
                    token_kind_i == KIND_LBRACE || token_kind_i == KIND_RBRACE ||
                    token_kind_i == KIND_LBRACK || token_kind_i == KIND_RBRACK ||
                    token_kind_i == KIND_ERROR)
      |-> token_length_i == OUT_BITS'(1))
    else $error("Punctuation or error token must have length one.");

endmodule

bind json_token_lexer_core jtl_checker u_jtl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_offset_i (out_o.token_offset),
  .token_length_i (out_o.token_length),
  .last_of_run_i  (out_o.last_of_run)
);

`default_nettype wire

[tb/json_token_lexer_core_tb.sv]
`timescale 1ns / 100ps

module json_token_lexer_core_tb;
  import jtl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 250;

  typedef enum logic [1:0] {
    LEX_IDLE = 2'd0,
    LEX_STR  = 2'd1,
    LEX_INT  = 2'd2,
    LEX_FRAC = 2'd3
  } lex_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } text_byte_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] line;
    logic        last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jtl_byte_if  byte_ch ();
  jtl_token_if token_ch ();

  json_token_lexer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (token_ch)
  );

  always #5 clk_i = ~clk_i;

  text_byte_t text_q[$];
  token_t     tokens_due[$];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;

  lex_mode_e lex_mode;
  pos_t      lex_pos;
  pos_t      lex_begin;
  line_t     lex_line;

  int send_idle = 0;
  int send_quiet = 0;
  int take_stall = 0;
  int take_quiet = 0;

  function automatic int pick_idle(ref int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  task automatic add_token(input kind_e kind, input pos_t offset, input pos_t length);
    token_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = length;
    t.line   = lex_line;
    t.last   = 1'b0;
    tokens_due.push_back(t);
  endtask

  task automatic classify(input logic [7:0] b, input pos_t here);
    case (b)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: lex_line = lex_line + 1'b1;
      CH_COLON: add_token(KIND_COLON, here, 1);
      CH_COMMA: add_token(KIND_COMMA, here, 1);
      CH_LBRACE: add_token(KIND_LBRACE, here, 1);
      CH_RBRACE: add_token(KIND_RBRACE, here, 1);
      CH_LBRACK: add_token(KIND_LBRACK, here, 1);
      CH_RBRACK: add_token(KIND_RBRACK, here, 1);
      CH_QUOTE: begin
        lex_mode  = LEX_STR;
        lex_begin = here + 1'b1;
      end
      default: begin
        if (b == CH_MINUS || is_digit(b)) begin
          lex_mode  = LEX_INT;
          lex_begin = here;
        end else begin
          add_token(KIND_ERROR, here, 1);
        end
      end
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic fin);
    pos_t   here;
    pos_t   nxt;
    int     before_cnt;
    token_t t;
    before_cnt = tokens_due.size();
    here = lex_pos;
    nxt  = lex_pos + 1'b1;
    case (lex_mode)
      LEX_STR: begin
        if (b == CH_QUOTE) begin
          add_token(KIND_STRING, lex_begin, here - lex_begin);
          lex_mode = LEX_IDLE;
        end
      end
      LEX_INT, LEX_FRAC: begin
        if (is_digit(b)) begin
        end else if (b == CH_DOT && lex_mode == LEX_INT) begin
          lex_mode = LEX_FRAC;
        end else begin
          add_token(KIND_NUMBER, lex_begin, here - lex_begin);
          lex_mode = LEX_IDLE;
          classify(b, here);
        end
      end
      default: classify(b, here);
    endcase
    lex_pos = nxt;
    if (fin) begin
      if (lex_mode == LEX_STR) begin
        add_token(KIND_STRING, lex_begin, nxt - lex_begin);
      end else if (lex_mode == LEX_INT || lex_mode == LEX_FRAC) begin
        add_token(KIND_NUMBER, lex_begin, nxt - lex_begin);
      end
      add_token(KIND_END, nxt, 0);
      lex_mode  = LEX_IDLE;
      lex_pos   = '0;
      lex_begin = '0;
      lex_line  = '0;
    end
    if (tokens_due.size() > before_cnt) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic fin);
    text_byte_t e;
    e.data = b;
    e.fin  = fin;
    text_q.push_back(e);
    bytes_queued++;
  endtask

  task automatic mark_final();
    text_byte_t e;
    e = text_q.pop_back();
    e.fin = 1'b1;
    text_q.push_back(e);
  endtask

  task automatic put_string(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || $urandom_range(0, 9) == 0) b = CH_LF;
      put_byte(b, 1'b0);
    end
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  task automatic put_text(input int n_tok);
    logic [7:0] punct[6];
    logic [7:0] blank[4];
    punct = '{CH_COLON, CH_COMMA, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};
    blank = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    for (int i = 0; i < n_tok; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put_byte(punct[$urandom_range(0, 5)], 1'b0);
        3, 4: begin
          repeat ($urandom_range(1, 3)) put_byte(blank[$urandom_range(0, 3)], 1'b0);
        end
        5, 6: begin
          put_byte(CH_QUOTE, 1'b0);
          put_string($urandom_range(0, 6));
          put_byte(CH_QUOTE, 1'b0);
        end
        7, 8: begin
          if ($urandom_range(0, 2) == 0) put_byte(CH_MINUS, 1'b0);
          put_digits($urandom_range(0, 4));
          if ($urandom_range(0, 2) == 0) begin
            put_byte(CH_DOT, 1'b0);
            put_digits($urandom_range(0, 3));
          end
        end
        default: begin
          if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
          else put_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0: begin
        put_byte(CH_QUOTE, 1'b0);
        put_string($urandom_range(0, 4));
      end
      1: put_digits($urandom_range(1, 3));
      default: put_byte(punct[$urandom_range(0, 5)], 1'b0);
    endcase
    mark_final();
  endtask

  always @(posedge clk_i) begin
    logic stalled;
    text_byte_t e;
    if (!rst_ni) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.data_byte  <= '0;
      byte_ch.final_byte <= 1'b0;
    end else begin
      stalled = byte_ch.valid && !byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        lex_byte(byte_ch.data_byte, byte_ch.final_byte);
        bytes_taken++;
      end
      if (!stalled) begin
        if (send_idle > 0) begin
          send_idle--;
          byte_ch.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          e = text_q.pop_front();
          byte_ch.valid      <= 1'b1;
          byte_ch.data_byte  <= e.data;
          byte_ch.final_byte <= e.fin;
          send_idle = pick_idle(send_quiet);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      token_ch.ready <= 1'b0;
    end else if (take_stall > 0) begin
      take_stall--;
      token_ch.ready <= 1'b0;
    end else begin
      token_ch.ready <= 1'b1;
      if ((token_ch.valid && token_ch.ready) || $urandom_range(0, 19) == 0) begin
        take_stall = pick_idle(take_quiet);
      end
    end
  end

  always @(posedge clk_i) begin
    token_t t;
    if (rst_ni && token_ch.valid && token_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d offset %0d", token_ch.token_kind,
               token_ch.token_offset);
        mismatch_cnt++;
      end else begin
        t = tokens_due.pop_front();
        if (token_ch.token_kind !== t.kind) begin
          $error("token_kind: expected %0d, got %0d", t.kind, token_ch.token_kind);
          mismatch_cnt++;
        end
        if (token_ch.token_offset !== t.offset) begin
          $error("token_offset: expected %0d, got %0d", t.offset, token_ch.token_offset);
          mismatch_cnt++;
        end
        if (token_ch.token_length !== t.length) begin
          $error("token_length: expected %0d, got %0d", t.length, token_ch.token_length);
          mismatch_cnt++;
        end
        if (token_ch.line_index !== t.line) begin
          $error("line_index: expected %0d, got %0d", t.line, token_ch.line_index);
          mismatch_cnt++;
        end
        if (token_ch.last_of_run !== t.last) begin
          $error("last_of_run: expected %0d, got %0d", t.last, token_ch.last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.final_byte = 1'b0;
    token_ch.ready     = 1'b0;
    lex_mode  = LEX_IDLE;
    lex_pos   = '0;
    lex_begin = '0;
    lex_line  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Strings with a newline, "-." and "1." numbers, whitespace, error bytes,
    // and texts that end on punctuation after a number, in a string and in a number.
    put_byte(CH_LBRACE, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte("a", 1'b0);
    put_byte(CH_LF, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(CH_COLON, 1'b0);
    put_byte(CH_MINUS, 1'b0);
    put_byte(CH_DOT, 1'b0);
    put_byte(CH_COMMA, 1'b0);
    put_byte("1", 1'b0);
    put_byte(CH_DOT, 1'b0);
    put_byte(CH_RBRACK, 1'b0);
    put_byte(CH_LBRACK, 1'b0);
    put_byte(CH_TAB, 1'b0);
    put_byte(CH_CR, 1'b0);
    put_byte(CH_SPACE, 1'b0);
    put_byte(CH_LF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(CH_MINUS, 1'b0);
    put_byte("7", 1'b0);
    put_byte(CH_RBRACE, 1'b1);
    put_byte(CH_QUOTE, 1'b0);
    put_byte("b", 1'b1);
    put_byte("4", 1'b1);

    // The sender holds off here until every token of the first part is out.
    while (bytes_taken < bytes_queued || tokens_due.size() > 0) @(posedge clk_i);

    while (bytes_queued < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 99) < 80) begin
        put_text($urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)),
                                                $urandom_range(0, 19) == 0);
      end
    end

    while (bytes_taken < bytes_queued || tokens_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && tokens_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
